// File: design/lmrs_pkg.sv
// shared types and constants of the led matrix row scroller
package lmrs_pkg;

    localparam int ROWS_DEFAULT    = 8;
    localparam int MODULES_DEFAULT = 7;
    localparam int MAX_STEP        = 8;

    // configuration register indexes
    localparam logic CFG_DISPLAY_MODE = 1'b0;
    localparam logic CFG_STEP_SIZE    = 1'b1;

    // display mode codes
    localparam logic [2:0] MODE_SHIFT_LEFT  = 3'd0;
    localparam logic [2:0] MODE_SHIFT_RIGHT = 3'd1;
    localparam logic [2:0] MODE_INV_LEFT    = 3'd2;
    localparam logic [2:0] MODE_INV_RIGHT   = 3'd3;
    localparam logic [2:0] MODE_STATIC      = 3'd4;
    localparam logic [2:0] MODE_HOLD        = 3'd5;

    localparam logic [2:0] MODE_RESET = MODE_SHIFT_RIGHT;
    localparam logic [3:0] STEP_RESET = 4'd1;

    typedef enum logic [1:0] {
        OP_LEFT,
        OP_RIGHT,
        OP_WRITE,
        OP_HOLD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] row;
        logic [3:0] step;
        logic [7:0] feed;
        logic [2:0] target;
    } cmd_t;

endpackage

// File: design/lmrs_front.sv
// front end: configuration registers and classification of each item into a command
module lmrs_front #(
    parameter int MODULES = lmrs_pkg::MODULES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_addr,
    input  logic [3:0]     cfg_wdata,
    input  logic [2:0]     row_index,
    input  logic [7:0]     glyph_row,
    input  logic [2:0]     scroll_phase,
    input  logic [2:0]     module_slot,
    output lmrs_pkg::cmd_t cmd
);

    logic [2:0] mode_reg;
    logic [3:0] step_reg;
    logic [3:0] step_sat;
    logic [7:0] prod;
    logic [3:0] k;
    logic [7:0] glyph_inv;
    logic       slot_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lmrs_pkg::MODE_RESET;
            step_reg <= lmrs_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == lmrs_pkg::CFG_DISPLAY_MODE)
            begin
                mode_reg <= cfg_wdata[2:0];
            end
            else
            begin
                step_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        step_sat  = (step_reg > 4'(lmrs_pkg::MAX_STEP)) ? 4'(lmrs_pkg::MAX_STEP) : step_reg;
        // glyph shift k: 8 - step*(phase+1), clamped at zero
        prod      = 8'(step_sat) * (8'(scroll_phase) + 8'd1);
        k         = (prod >= 8'd8) ? 4'd0 : 4'(8'd8 - prod);
        glyph_inv = ~glyph_row;
        slot_ok   = ({1'b0, module_slot} < 4'(MODULES));

        cmd.row    = row_index;
        cmd.step   = step_sat;
        cmd.op     = lmrs_pkg::OP_HOLD;
        cmd.feed   = glyph_row;
        cmd.target = 3'(MODULES - 1) - module_slot;

        case (mode_reg)
            lmrs_pkg::MODE_SHIFT_LEFT:
            begin
                cmd.op   = lmrs_pkg::OP_LEFT;
                cmd.feed = glyph_row >> k;
            end
            lmrs_pkg::MODE_INV_LEFT:
            begin
                cmd.op   = lmrs_pkg::OP_LEFT;
                cmd.feed = glyph_inv >> k;
            end
            lmrs_pkg::MODE_SHIFT_RIGHT:
            begin
                cmd.op   = lmrs_pkg::OP_RIGHT;
                cmd.feed = glyph_row << k;
            end
            lmrs_pkg::MODE_INV_RIGHT:
            begin
                cmd.op   = lmrs_pkg::OP_RIGHT;
                cmd.feed = glyph_inv << k;
            end
            lmrs_pkg::MODE_STATIC:
            begin
                // slot beyond the chain leaves the row alone
                cmd.op = slot_ok ? lmrs_pkg::OP_WRITE : lmrs_pkg::OP_HOLD;
            end
            default:
            begin
                cmd.op = lmrs_pkg::OP_HOLD;
            end
        endcase
    end

endmodule

// File: design/lmrs_queue.sv
// two-entry command queue between front and back
module lmrs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lmrs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output lmrs_pkg::cmd_t head
);

    lmrs_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/lmrs_back.sv
// back end: frame row file, row read-modify-write and output register
module lmrs_back #(
    parameter int ROWS    = lmrs_pkg::ROWS_DEFAULT,
    parameter int MODULES = lmrs_pkg::MODULES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  lmrs_pkg::cmd_t         cmd,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [8*MODULES-1:0]   row_bits,
    output logic [2:0]             row_echo
);

    localparam int W  = 8 * MODULES;
    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [W-1:0] frame_reg [ROWS];
    logic         out_valid_reg;
    logic [W-1:0] row_bits_reg;
    logic [2:0]   row_echo_reg;

    logic [4:0]    row_wide;
    logic [AW-1:0] row_addr;
    logic          row_ok;
    logic [W-1:0]  cur;
    logic [W-1:0]  upd;
    logic [5:0]    pos;

    assign cmd_pop   = cmd_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign row_bits  = row_bits_reg;
    assign row_echo  = row_echo_reg;

    always_comb
    begin
        row_wide = {2'b00, cmd.row};
        row_addr = row_wide[AW-1:0];
        row_ok   = (row_wide < 5'(ROWS));
        cur      = frame_reg[row_addr];
        pos      = {cmd.target, 3'b000};
        case (cmd.op)
            lmrs_pkg::OP_LEFT:
            begin
                upd = (cur << cmd.step) | W'(cmd.feed);
            end
            lmrs_pkg::OP_RIGHT:
            begin
                // feed lands in the top module
                upd = (cur >> cmd.step) | (W'(cmd.feed) << (W - 8));
            end
            lmrs_pkg::OP_WRITE:
            begin
                upd = (cur & ~(W'(8'hFF) << pos)) | (W'(cmd.feed) << pos);
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                frame_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd_pop)
            begin
                out_valid_reg <= 1'b1;
                if (row_ok)
                begin
                    frame_reg[row_addr] <= upd;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            row_bits_reg <= row_ok ? upd : '0;
            row_echo_reg <= cmd.row;
        end
    end

endmodule

// File: design/led_matrix_row_scroller.sv
// top level of the led matrix row scroller
// an item passes through the queue register, then the back end output register
// throughput: one item per cycle while out_ready stays high, set by the row
// read-modify-write in the back end; a two-entry queue decouples front and back
// reset: all frame rows clear to zero, display mode to shift right, step size to 1
module led_matrix_row_scroller #(
    parameter int ROWS    = lmrs_pkg::ROWS_DEFAULT,
    parameter int MODULES = lmrs_pkg::MODULES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [3:0]           cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           row_index,
    input  logic [7:0]           glyph_row,
    input  logic [2:0]           scroll_phase,
    input  logic [2:0]           module_slot,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [8*MODULES-1:0] row_bits,
    output logic [2:0]           row_echo
);

    lmrs_pkg::cmd_t front_cmd;
    lmrs_pkg::cmd_t head_cmd;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    assign in_ready = !q_full;

    lmrs_front #(
        .MODULES(MODULES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .row_index    (row_index),
        .glyph_row    (glyph_row),
        .scroll_phase (scroll_phase),
        .module_slot  (module_slot),
        .cmd          (front_cmd)
    );

    lmrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid && !q_full),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    lmrs_back #(
        .ROWS    (ROWS),
        .MODULES (MODULES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row_bits  (row_bits),
        .row_echo  (row_echo)
    );

endmodule

// File: verif/tb_led_matrix_row_scroller.sv
`timescale 1ns / 100ps
// testbench of the led matrix row scroller: directed rows, then random phases vs a predictor
module tb_led_matrix_row_scroller;

    localparam int N_ROWS     = lmrs_pkg::ROWS_DEFAULT;
    localparam int N_MODULES  = lmrs_pkg::MODULES_DEFAULT;
    localparam int WIDTH      = 8 * N_MODULES;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_PHASES   = 24;
    localparam int PHASE_LEN  = 50;

    // codes the package leaves unnamed; the block treats them as hold
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]       mode;
        logic [3:0]       step;
        logic [2:0]       row;
        logic [7:0]       glyph;
        logic [2:0]       phase;
        logic [2:0]       slot;
        logic             typed;
        logic [WIDTH-1:0] bits;
    } directed_row_t;

    typedef struct {
        logic [WIDTH-1:0] bits;
        logic [2:0]       row;
    } row_update_t;

    localparam directed_row_t DIRECTED[23] = '{
        '{lmrs_pkg::MODE_SHIFT_RIGHT, 4'd1,  3'd0, 8'hFF, 3'd0, 3'd0, 1'b1, 56'h80000000000000},
        '{lmrs_pkg::MODE_STATIC,      4'd1,  3'd1, 8'hA5, 3'd0, 3'd0, 1'b1, 56'hA5000000000000},
        '{lmrs_pkg::MODE_STATIC,      4'd1,  3'd1, 8'h3C, 3'd0, 3'd6, 1'b1, 56'hA500000000003C},
        '{lmrs_pkg::MODE_STATIC,      4'd1,  3'd1, 8'hFF, 3'd7, 3'd7, 1'b1, 56'hA500000000003C},
        '{lmrs_pkg::MODE_HOLD,        4'd1,  3'd1, 8'h12, 3'd0, 3'd0, 1'b1, 56'hA500000000003C},
        '{MODE_SPARE6,                4'd1,  3'd1, 8'h34, 3'd0, 3'd0, 1'b1, 56'hA500000000003C},
        '{MODE_SPARE7,                4'd1,  3'd1, 8'h56, 3'd0, 3'd0, 1'b1, 56'hA500000000003C},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd8,  3'd2, 8'hFF, 3'd0, 3'd0, 1'b1, 56'h000000000000FF},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd8,  3'd2, 8'h00, 3'd7, 3'd0, 1'b1, 56'h0000000000FF00},
        '{lmrs_pkg::MODE_INV_LEFT,    4'd8,  3'd2, 8'h00, 3'd0, 3'd0, 1'b1, 56'h00000000FF00FF},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd0,  3'd2, 8'hFF, 3'd0, 3'd0, 1'b1, 56'h00000000FF00FF},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd15, 3'd2, 8'hFF, 3'd0, 3'd0, 1'b1, 56'h000000FF00FFFF},
        '{lmrs_pkg::MODE_INV_RIGHT,   4'd8,  3'd3, 8'h00, 3'd0, 3'd0, 1'b1, 56'hFF000000000000},
        '{lmrs_pkg::MODE_SHIFT_RIGHT, 4'd15, 3'd3, 8'h5A, 3'd0, 3'd0, 1'b1, 56'h5AFF0000000000},
        '{lmrs_pkg::MODE_SHIFT_RIGHT, 4'd0,  3'd3, 8'hFF, 3'd7, 3'd0, 1'b1, 56'h5AFF0000000000},
        '{lmrs_pkg::MODE_SHIFT_RIGHT, 4'd2,  3'd4, 8'hFF, 3'd3, 3'd0, 1'b0, 56'h0},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd3,  3'd5, 8'h81, 3'd1, 3'd0, 1'b0, 56'h0},
        '{lmrs_pkg::MODE_INV_LEFT,    4'd1,  3'd7, 8'h7E, 3'd7, 3'd0, 1'b0, 56'h0},
        '{lmrs_pkg::MODE_INV_RIGHT,   4'd5,  3'd6, 8'hC3, 3'd2, 3'd0, 1'b0, 56'h0},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd8,  3'd2, 8'hAA, 3'd0, 3'd0, 1'b0, 56'h0},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd8,  3'd2, 8'hAA, 3'd0, 3'd0, 1'b0, 56'h0},
        '{lmrs_pkg::MODE_SHIFT_LEFT,  4'd8,  3'd2, 8'hAA, 3'd0, 3'd0, 1'b0, 56'h0},
        '{lmrs_pkg::MODE_STATIC,      4'd8,  3'd7, 8'hFF, 3'd5, 3'd3, 1'b0, 56'h0}
    };

    // the first random phases sweep every mode and the step extremes
    localparam logic [2:0] SWEEP_MODES[8] = '{
        lmrs_pkg::MODE_SHIFT_LEFT, lmrs_pkg::MODE_SHIFT_RIGHT, lmrs_pkg::MODE_INV_LEFT,
        lmrs_pkg::MODE_INV_RIGHT, lmrs_pkg::MODE_STATIC, lmrs_pkg::MODE_HOLD,
        MODE_SPARE6, MODE_SPARE7};
    localparam logic [3:0] SWEEP_STEPS[8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd2, 4'd8};

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             cfg_we       = 1'b0;
    logic             cfg_addr     = lmrs_pkg::CFG_DISPLAY_MODE;
    logic [3:0]       cfg_wdata    = 4'd0;
    logic             in_valid     = 1'b0;
    logic             in_ready;
    logic [2:0]       row_index    = 3'd0;
    logic [7:0]       glyph_row    = 8'd0;
    logic [2:0]       scroll_phase = 3'd0;
    logic [2:0]       module_slot  = 3'd0;
    logic             out_valid;
    logic             out_ready    = 1'b0;
    logic [WIDTH-1:0] row_bits;
    logic [2:0]       row_echo;

    // predictor state, kept in step with the block
    logic [WIDTH-1:0] frame_shadow[N_ROWS];
    logic [2:0]       mode_shadow = lmrs_pkg::MODE_RESET;
    logic [3:0]       step_shadow = lmrs_pkg::STEP_RESET;

    row_update_t      rows_due[$];
    int               items_taken  = 0;
    int               failures     = 0;
    int               idle_cycles  = 0;
    int               stall_left   = 0;
    bit               no_idle      = 1'b0;
    bit               typed_check  = 1'b0;
    logic [WIDTH-1:0] typed_bits   = '0;

    led_matrix_row_scroller DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_index    (row_index),
        .glyph_row    (glyph_row),
        .scroll_phase (scroll_phase),
        .module_slot  (module_slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_bits     (row_bits),
        .row_echo     (row_echo)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int r = 0; r < N_ROWS; r++)
            frame_shadow[r] = '0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return int'($urandom_range(1, 3));
        else if (pick < 98)
            return int'($urandom_range(4, 10));
        else
            return int'($urandom_range(20, 40));
    endfunction

    // applies one item to the shadow frame and returns the row it leaves
    function automatic logic [WIDTH-1:0] next_row_bits(logic [2:0] row, logic [7:0] glyph,
                                                       logic [2:0] phase, logic [2:0] slot);
        int         s;
        int         k;
        int         pos;
        logic [7:0] g;
        logic [63:0] v;
        s = (step_shadow > 4'd8) ? 8 : int'(step_shadow);
        k = 8 - s - int'(phase) * s;
        if (k < 0)
            k = 0;
        g = glyph;
        v = {8'h00, frame_shadow[row]};
        case (mode_shadow)
            lmrs_pkg::MODE_SHIFT_LEFT, lmrs_pkg::MODE_INV_LEFT:
            begin
                if (mode_shadow == lmrs_pkg::MODE_INV_LEFT)
                    g = ~g;
                v = (v << s) | (64'(g) >> k);
            end
            lmrs_pkg::MODE_SHIFT_RIGHT, lmrs_pkg::MODE_INV_RIGHT:
            begin
                if (mode_shadow == lmrs_pkg::MODE_INV_RIGHT)
                    g = ~g;
                // only the glyph bits that stay inside a byte enter the top module
                v = (v >> s) | (((64'(g) << k) & 64'hFF) << (8 * (N_MODULES - 1)));
            end
            lmrs_pkg::MODE_STATIC:
            begin
                if (int'(slot) < N_MODULES)
                begin
                    pos = 8 * (N_MODULES - 1 - int'(slot));
                    v[pos +: 8] = g;
                end
            end
            default:
            begin
            end
        endcase
        frame_shadow[row] = v[WIDTH-1:0];
        return v[WIDTH-1:0];
    endfunction

    // scoreboard, shadow register update and watchdog
    always @(posedge clk)
    begin : score
        row_update_t want;
        bit          busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                busy = 1'b1;
                if (rows_due.size() == 0)
                begin
                    $error("row update with none expected: row_echo %0d", row_echo);
                    failures++;
                end
                else
                begin
                    want = rows_due.pop_front();
                    if (row_bits !== want.bits)
                    begin
                        $error("row_bits: expected %h, actual %h", want.bits, row_bits);
                        failures++;
                    end
                    if (row_echo !== want.row)
                    begin
                        $error("row_echo: expected %0d, actual %0d", want.row, row_echo);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                busy = 1'b1;
                want.row  = row_index;
                want.bits = next_row_bits(row_index, glyph_row, scroll_phase, module_slot);
                if (typed_check)
                    want.bits = typed_bits;
                rows_due.push_back(want);
                items_taken++;
            end
            if (cfg_we)
            begin
                if (cfg_addr == lmrs_pkg::CFG_DISPLAY_MODE)
                    mode_shadow = cfg_wdata[2:0];
                else
                    step_shadow = cfg_wdata;
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver stalls, with calm stretches when no_idle is set
    always @(negedge clk)
    begin
        if (rst_n && stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= rst_n;
            if (!no_idle)
                stall_left = gap_len();
        end
    end

    task automatic send_item(logic [2:0] row, logic [7:0] glyph, logic [2:0] phase,
                             logic [2:0] slot, bit typed, logic [WIDTH-1:0] bits);
        int gap;
        int target;
        gap = no_idle ? 0 : gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        row_index    <= row;
        glyph_row    <= glyph;
        scroll_phase <= phase;
        module_slot  <= slot;
        typed_check  = typed;
        typed_bits   = bits;
        target       = items_taken + 1;
        do
            @(negedge clk);
        while (items_taken != target);
    endtask

    task automatic drain_rows();
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic addr, logic [3:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode_step(logic [2:0] mode, logic [3:0] step);
        drain_rows();
        // the spare top bit of the data bus must be ignored for the mode register
        write_reg(lmrs_pkg::CFG_DISPLAY_MODE, {1'($urandom_range(0, 1)), mode});
        write_reg(lmrs_pkg::CFG_STEP_SIZE, step);
    endtask

    initial
    begin
        logic [2:0] mode;
        logic [3:0] step;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].mode != mode_shadow || DIRECTED[i].step != step_shadow)
                set_mode_step(DIRECTED[i].mode, DIRECTED[i].step);
            send_item(DIRECTED[i].row, DIRECTED[i].glyph, DIRECTED[i].phase,
                      DIRECTED[i].slot, DIRECTED[i].typed, DIRECTED[i].bits);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 8)
            begin
                mode = SWEEP_MODES[ph];
                step = SWEEP_STEPS[ph];
            end
            else
            begin
                // shift modes carry most of the behavior
                mode = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 3))
                                                   : 3'($urandom_range(4, 7));
                step = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
            end
            set_mode_step(mode, step);
            no_idle = (ph % 5 == 3);
            for (int n = 0; n < PHASE_LEN; n++)
                send_item(3'($urandom_range(0, 7)), 8'($urandom), 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), 1'b0, '0);
        end

        in_valid <= 1'b0;
        no_idle = 1'b0;
        while (rows_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
